[src/pnrs_pkg.sv]
package pnrs_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int TAB_LEN          = 24;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Quotient width of the rate divider: |dlos| * 2^16 + step/2 stays below 2^33.
   localparam int DIV_NUM_W = 33;
   localparam int DIV_DEN_W = 16;

   // Arctangents of 2^-i, truncated Q2.30.
   localparam logic [31:0] ATAN_Q30 [TAB_LEN] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127
   };
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   // 180/pi in Q16.
   localparam logic [22:0] R2D_Q16 = 23'd3754936;

   localparam logic [15:0] NAV_GAIN_RST         = 16'd8192;
   localparam logic [15:0] ROLL_GAIN_RST        = 16'd8192;
   localparam logic [11:0] SERVO_CENTER_RST     = 12'd1500;
   localparam logic [15:0] PULSE_PER_DEGREE_RST = 16'd15097;
   localparam logic [15:0] GRAVITY_RST          = 16'd2507;

   localparam logic [11:0] PULSE_MAX = 12'd4095;

   typedef enum logic [2:0] {
      REG_NAV_GAIN         = 3'd0,
      REG_ROLL_GAIN        = 3'd1,
      REG_SERVO_CENTER     = 3'd2,
      REG_PULSE_PER_DEGREE = 3'd3,
      REG_GRAVITY          = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] speed;
      logic signed [15:0] prev_los;
      logic signed [15:0] roll_now;
      logic [15:0]        step_time;
   } front_side_type;

   typedef struct packed {
      logic signed [15:0] los;
      logic               bad;
      logic signed [15:0] roll_now;
   } back_side_type;

   typedef struct packed {
      back_side_type      back;
      logic               neg;
      logic signed [15:0] speed;
   } div_side_type;

   // Q2.30 angle rounded half up to ab fraction bits.
   function automatic logic [32:0] q30_round(input logic [31:0] a, input int ab);
      logic [32:0] r;
      r = ({1'b0, a} + (33'd1 << (29 - ab))) >> (30 - ab);
      return r;
   endfunction

endpackage

[src/pnrs_chan_if.sv]
interface pnrs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] rel_north;
   logic signed [31:0] rel_east;
   logic signed [15:0] speed;
   logic signed [15:0] prev_los;
   logic signed [15:0] roll_now;
   logic [15:0]        step_time;

   modport source (output valid, rel_north, rel_east, speed, prev_los, roll_now, step_time,
                   input ready);
   modport sink (input valid, rel_north, rel_east, speed, prev_los, roll_now, step_time,
                 output ready);
endinterface

interface pnrs_rsp_if;
   logic               valid;
   logic               ready;
   logic [11:0]        servo_pulse;
   logic signed [15:0] los_now;
   logic               saturated;
   logic               bad_step;

   modport source (output valid, servo_pulse, los_now, saturated, bad_step, input ready);
   modport sink (input valid, servo_pulse, los_now, saturated, bad_step, output ready);
endinterface

[src/pnrs_cordic.sv]
module pnrs_cordic #(
   parameter int STEPS      = pnrs_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS = pnrs_pkg::ANGLE_BITS_DEF,
   parameter int W          = 36,
   parameter int SIDE_W     = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic                         in_zero,
   input  logic signed [W-1:0]          in_x,
   input  logic signed [W-1:0]          in_y,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic signed [ANGLE_BITS+2:0] out_z,
   output logic [SIDE_W-1:0]            out_side
);
   import pnrs_pkg::*;

   localparam int ZW = ANGLE_BITS + 3;
   localparam logic signed [ZW-1:0] HALF_PI = ZW'(q30_round(HALF_PI_Q30, ANGLE_BITS));

   logic                valid_ff [STEPS+1];
   logic                zero_ff  [STEPS+1];
   logic signed [W-1:0] x_ff     [STEPS+1];
   logic signed [W-1:0] y_ff     [STEPS+1];
   logic signed [ZW-1:0] z_ff    [STEPS+1];
   logic [SIDE_W-1:0]   side_ff  [STEPS+1];

   logic signed [W-1:0]  x_in, y_in;
   logic signed [ZW-1:0] z_in;

   // A left half-plane vector is turned by a quarter turn first.
   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = in_y;
            y_in = -in_x;
            z_in = HALF_PI;
         end else begin
            x_in = -in_y;
            y_in = in_x;
            z_in = -HALF_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= in_zero;
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_iter
      localparam logic signed [ZW-1:0] ANG = ZW'(q30_round(ATAN_Q30[k], ANGLE_BITS));
      logic signed [W-1:0] dx, dy;

      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[k+1] <= zero_ff[k];
            side_ff[k+1] <= side_ff[k];
            if (y_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + ANG;
            end else begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - ANG;
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_z     = zero_ff[STEPS] ? '0 : z_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

[src/pnrs_divider.sv]
module pnrs_divider #(
   parameter int SIDE_W = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [pnrs_pkg::DIV_NUM_W-1:0]      in_num,
   input  logic [pnrs_pkg::DIV_DEN_W-1:0]      in_den,
   input  logic [SIDE_W-1:0]                   in_side,
   output logic                                out_valid,
   output logic [pnrs_pkg::DIV_NUM_W-1:0]      out_quo,
   output logic [SIDE_W-1:0]                   out_side
);
   import pnrs_pkg::*;

   localparam int NW = DIV_NUM_W;
   localparam int DW = DIV_DEN_W;

   // One quotient bit per stage; the dividend shifts out at the top while
   // quotient bits shift in at the bottom.
   logic          valid_ff [NW+1];
   logic [NW-1:0] num_ff   [NW+1];
   logic [DW-1:0] rem_ff   [NW+1];
   logic [DW-1:0] den_ff   [NW+1];
   logic [SIDE_W-1:0] side_ff [NW+1];

   always_comb begin
      valid_ff[0] = in_valid;
      num_ff[0]   = in_num;
      rem_ff[0]   = '0;
      den_ff[0]   = in_den;
      side_ff[0]  = in_side;
   end

   for (genvar k = 0; k < NW; k++) begin : g_bit
      logic [DW:0] trial;
      logic        take;

      assign trial = {rem_ff[k], num_ff[k][NW-1]};
      assign take  = trial >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
            num_ff[k+1]  <= {num_ff[k][NW-2:0], take};
            rem_ff[k+1]  <= take ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];
         end
      end
   end

   assign out_valid = valid_ff[NW];
   assign out_quo   = num_ff[NW];
   assign out_side  = side_ff[NW];

endmodule

[src/pro_nav_roll_servo_command_unit.sv]
// Proportional navigation roll servo command. Each word on req_ch carries the glider's
// offset from the target, its speed, the previous line-of-sight angle, its roll and the
// time step; rsp_ch returns the servo pulse, the new line-of-sight angle and two flags.
// The unit is a single pipeline that takes one word every clock cycle while no result waits
// on rsp_ch, and returns the results in order. Most of its depth lies in the two
// CORDIC pipelines (CORDIC_STEPS+1 stages each) and the 33-stage radix-2 divider that
// forms the line-of-sight rate. When a result waits on rsp_ch the whole pipeline holds
// and req_ch.ready drops. The user writes registers over the csr_ APB port only while no
// word is in flight; the unit itself does not enforce this.
module pro_nav_roll_servo_command_unit #(
   parameter int CORDIC_STEPS = pnrs_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = pnrs_pkg::ANGLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pnrs_req_if.sink                          req_ch,
   pnrs_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pnrs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pnrs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pnrs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import pnrs_pkg::*;

   localparam int ZW     = ANGLE_BITS + 3;
   localparam int LOS_SH = ANGLE_BITS - 13;
   localparam int W1     = 36;
   localparam int W2     = 43;
   localparam int PW     = ZW + 24;
   localparam logic signed [PW-1:0] R2D_HALF = PW'(1) <<< (ANGLE_BITS + 8);
   localparam logic signed [51:0]   OFF_HALF = 52'sd1 <<< 26;

   // ---------------- configuration ----------------
   logic [15:0] nav_gain_ff, roll_gain_ff, ppd_ff, gravity_ff;
   logic [11:0] center_ff;
   reg_index_type csr_index;

   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nav_gain_ff  <= NAV_GAIN_RST;
         roll_gain_ff <= ROLL_GAIN_RST;
         center_ff    <= SERVO_CENTER_RST;
         ppd_ff       <= PULSE_PER_DEGREE_RST;
         gravity_ff   <= GRAVITY_RST;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            REG_NAV_GAIN:         nav_gain_ff  <= csr_pwdata[15:0];
            REG_ROLL_GAIN:        roll_gain_ff <= csr_pwdata[15:0];
            REG_SERVO_CENTER:     center_ff    <= csr_pwdata[11:0];
            REG_PULSE_PER_DEGREE: ppd_ff       <= csr_pwdata[15:0];
            REG_GRAVITY:          gravity_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_NAV_GAIN:         csr_prdata = {16'b0, nav_gain_ff};
         REG_ROLL_GAIN:        csr_prdata = {16'b0, roll_gain_ff};
         REG_SERVO_CENTER:     csr_prdata = {20'b0, center_ff};
         REG_PULSE_PER_DEGREE: csr_prdata = {16'b0, ppd_ff};
         REG_GRAVITY:          csr_prdata = {16'b0, gravity_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic out_v_ff;
   logic advance;

   assign advance      = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // ---------------- entry: line of sight points from glider to target ----------------
   logic                 v0_ff, zero0_ff;
   logic signed [W1-1:0] x0_ff, y0_ff;
   front_side_type       side0_ff, side0_in;

   always_comb begin
      side0_in.speed     = req_ch.speed;
      side0_in.prev_los  = req_ch.prev_los;
      side0_in.roll_now  = req_ch.roll_now;
      side0_in.step_time = req_ch.step_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff    <= -W1'(req_ch.rel_north);
         y0_ff    <= -W1'(req_ch.rel_east);
         zero0_ff <= (req_ch.rel_north == 32'sd0) && (req_ch.rel_east == 32'sd0);
         side0_ff <= side0_in;
      end
   end

   logic                 c1_v;
   logic signed [ZW-1:0] c1_z;
   logic [$bits(front_side_type)-1:0] c1_side_raw;
   front_side_type       c1_side;

   pnrs_cordic #(
      .STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS), .W(W1), .SIDE_W($bits(front_side_type))
   ) u_los_cordic (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v0_ff), .in_zero(zero0_ff), .in_x(x0_ff), .in_y(y0_ff), .in_side(side0_ff),
      .out_valid(c1_v), .out_z(c1_z), .out_side(c1_side_raw)
   );

   assign c1_side = front_side_type'(c1_side_raw);

   // ---------------- angle to Q3.13, rate dividend ----------------
   logic signed [ZW:0]  los_wide;
   logic signed [15:0]  los_c;
   logic signed [16:0]  dlos;
   logic [16:0]         dlos_mag;
   logic [DIV_NUM_W-1:0] num_in;
   div_side_type        dside_in;

   if (LOS_SH > 0) begin : g_los_round
      assign los_wide = ((ZW+1)'(c1_z) + (ZW+1)'(1 <<< (LOS_SH - 1))) >>> LOS_SH;
   end else begin : g_los_scale
      assign los_wide = (ZW+1)'(c1_z) <<< (-LOS_SH);
   end

   always_comb begin
      if (los_wide > 32767) begin
         los_c = 16'sh7fff;
      end else if (los_wide < -32768) begin
         los_c = -16'sh8000;
      end else begin
         los_c = 16'(los_wide);
      end
      dlos     = 17'(los_c) - 17'(c1_side.prev_los);
      dlos_mag = dlos < 0 ? 17'(-dlos) : 17'(dlos);
      num_in   = {1'b0, dlos_mag[15:0], 16'b0} + DIV_NUM_W'(c1_side.step_time >> 1);
      dside_in.back.los      = los_c;
      dside_in.back.bad      = c1_side.step_time == 16'd0;
      dside_in.back.roll_now = c1_side.roll_now;
      dside_in.neg           = dlos < 0;
      dside_in.speed         = c1_side.speed;
   end

   logic                 lv_ff;
   logic [DIV_NUM_W-1:0] lnum_ff;
   logic [15:0]          lden_ff;
   div_side_type         lside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= 1'b0;
      end else if (advance) begin
         lv_ff <= c1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lnum_ff  <= num_in;
         lden_ff  <= c1_side.step_time;
         lside_ff <= dside_in;
      end
   end

   logic                 d_v;
   logic [DIV_NUM_W-1:0] d_quo;
   logic [$bits(div_side_type)-1:0] d_side_raw;
   div_side_type         d_side;

   pnrs_divider #(.SIDE_W($bits(div_side_type))) u_rate_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(lv_ff), .in_num(lnum_ff), .in_den(lden_ff), .in_side(lside_ff),
      .out_valid(d_v), .out_quo(d_quo), .out_side(d_side_raw)
   );

   assign d_side = div_side_type'(d_side_raw);

   // ---------------- lateral acceleration ----------------
   logic signed [33:0] rate_in;

   always_comb begin
      if (d_side.back.bad) begin
         rate_in = '0;
      end else if (d_side.neg) begin
         rate_in = -$signed({1'b0, d_quo});
      end else begin
         rate_in = $signed({1'b0, d_quo});
      end
   end

   logic               m1v_ff, m2v_ff, m3v_ff;
   logic signed [33:0] rate_ff;
   logic signed [32:0] ns_ff;
   logic signed [51:0] plo_ff;
   logic signed [48:0] phi_ff;
   logic signed [67:0] acc_ff;
   logic [40:0]        gx_ff;
   back_side_type      m1s_ff, m2s_ff, m3s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1v_ff <= 1'b0;
         m2v_ff <= 1'b0;
         m3v_ff <= 1'b0;
      end else if (advance) begin
         m1v_ff <= d_v;
         m2v_ff <= m1v_ff;
         m3v_ff <= m2v_ff;
      end
   end

   // The 33 x 34 bit product is split on the rate into two partial products.
   always_ff @(posedge clock) begin
      if (advance) begin
         ns_ff   <= $signed({1'b0, nav_gain_ff}) * d_side.speed;
         rate_ff <= rate_in;
         m1s_ff  <= d_side.back;
         plo_ff  <= ns_ff * $signed({1'b0, rate_ff[17:0]});
         phi_ff  <= ns_ff * $signed(rate_ff[33:18]);
         m2s_ff  <= m1s_ff;
         acc_ff  <= (68'(phi_ff) <<< 18) + 68'(plo_ff);
         gx_ff   <= {gravity_ff, 25'b0};
         m3s_ff  <= m2s_ff;
      end
   end

   // ---------------- operand scaling for the roll CORDIC ----------------
   logic          n1v_ff, n2v_ff;
   logic signed [67:0] acc1_ff, acc2_ff;
   logic [40:0]   gx1_ff, gx2_ff;
   logic [67:0]   orw_ff;
   back_side_type n1s_ff, n2s_ff;
   logic [67:0]   mag_in;
   logic [3:0]    nz_in, nz_ff;
   logic [4:0]    pos_in [4];
   logic [4:0]    pos_ff [4];

   assign mag_in = acc_ff < 0 ? 68'(-acc_ff) : 68'(acc_ff);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         nz_in[c]  = |orw_ff[17*c +: 17];
         pos_in[c] = '0;
         for (int j = 0; j < 17; j++) begin
            if (orw_ff[17*c + j]) begin
               pos_in[c] = 5'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1v_ff <= 1'b0;
         n2v_ff <= 1'b0;
      end else if (advance) begin
         n1v_ff <= m3v_ff;
         n2v_ff <= n1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         orw_ff  <= mag_in | {27'b0, gx_ff};
         acc1_ff <= acc_ff;
         gx1_ff  <= gx_ff;
         n1s_ff  <= m3s_ff;
         nz_ff   <= nz_in;
         pos_ff  <= pos_in;
         acc2_ff <= acc1_ff;
         gx2_ff  <= gx1_ff;
         n2s_ff  <= n1s_ff;
      end
   end

   // Both operands shift right together until the larger magnitude is below 2^40.
   logic [6:0] bitlen;
   logic [4:0] shamt;

   always_comb begin
      bitlen = '0;
      for (int c = 0; c < 4; c++) begin
         if (nz_ff[c]) begin
            bitlen = 7'(17 * c) + 7'(pos_ff[c]) + 7'd1;
         end
      end
      shamt = bitlen > 7'd40 ? 5'(bitlen - 7'd40) : 5'd0;
   end

   logic                 n3v_ff, zero2_ff;
   logic signed [W2-1:0] x2_ff, y2_ff;
   back_side_type        n3s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n3v_ff <= 1'b0;
      end else if (advance) begin
         n3v_ff <= n2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y2_ff    <= W2'(acc2_ff >>> shamt);
         x2_ff    <= $signed(W2'(gx2_ff >> shamt));
         zero2_ff <= nz_ff == 4'd0;
         n3s_ff   <= n2s_ff;
      end
   end

   logic                 c2_v;
   logic signed [ZW-1:0] c2_z;
   logic [$bits(back_side_type)-1:0] c2_side_raw;
   back_side_type        c2_side;

   pnrs_cordic #(
      .STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS), .W(W2), .SIDE_W($bits(back_side_type))
   ) u_roll_cordic (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(n3v_ff), .in_zero(zero2_ff), .in_x(x2_ff), .in_y(y2_ff), .in_side(n3s_ff),
      .out_valid(c2_v), .out_z(c2_z), .out_side(c2_side_raw)
   );

   assign c2_side = back_side_type'(c2_side_raw);

   // ---------------- roll error to servo pulse ----------------
   logic               r1v_ff, r2v_ff, r3v_ff, r4v_ff;
   logic signed [PW-1:0] deg_ff;
   logic signed [PW-1:0] rc_in;
   logic signed [17:0] err_ff;
   logic signed [34:0] off1_ff;
   logic signed [51:0] off_ff;
   back_side_type      r1s_ff, r2s_ff, r3s_ff, r4s_ff;

   assign rc_in = (deg_ff + R2D_HALF) >>> (ANGLE_BITS + 9);

   always_ff @(posedge clock) begin
      if (reset) begin
         r1v_ff <= 1'b0;
         r2v_ff <= 1'b0;
         r3v_ff <= 1'b0;
         r4v_ff <= 1'b0;
      end else if (advance) begin
         r1v_ff <= c2_v;
         r2v_ff <= r1v_ff;
         r3v_ff <= r2v_ff;
         r4v_ff <= r3v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         deg_ff  <= c2_z * $signed({1'b0, R2D_Q16});
         r1s_ff  <= c2_side;
         err_ff  <= $signed(rc_in[17:0]) - 18'(r1s_ff.roll_now);
         r2s_ff  <= r1s_ff;
         off1_ff <= $signed({1'b0, roll_gain_ff}) * err_ff;
         r3s_ff  <= r2s_ff;
         off_ff  <= off1_ff * $signed({1'b0, ppd_ff});
         r4s_ff  <= r3s_ff;
      end
   end

   logic signed [24:0] adj;
   logic signed [25:0] pulse_in;

   assign adj      = 25'((off_ff + OFF_HALF) >>> 27);
   assign pulse_in = $signed({14'b0, center_ff}) + 26'(adj);

   logic [11:0]        pulse_ff;
   logic signed [15:0] los_ff;
   logic               sat_ff, bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (advance) begin
         out_v_ff <= r4v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (pulse_in < 0) begin
            pulse_ff <= '0;
            sat_ff   <= 1'b1;
         end else if (pulse_in > 26'sd4095) begin
            pulse_ff <= PULSE_MAX;
            sat_ff   <= 1'b1;
         end else begin
            pulse_ff <= pulse_in[11:0];
            sat_ff   <= 1'b0;
         end
         los_ff <= r4s_ff.los;
         bad_ff <= r4s_ff.bad;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.servo_pulse = pulse_ff;
   assign rsp_ch.los_now     = los_ff;
   assign rsp_ch.saturated   = sat_ff;
   assign rsp_ch.bad_step    = bad_ff;

endmodule

[src/pnrs_checker.sv]
module pnrs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [11:0]        servo_pulse,
   input logic signed [15:0] los_now,
   input logic               saturated,
   input logic               bad_step
);
   import pnrs_pkg::*;

   // Nothing comes out of a pipeline that was just flushed.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // With no result waiting the pipeline never holds back input.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled although output is empty");

   // A clipped pulse sits at one of the range ends.
   a_sat_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |-> servo_pulse == '0 || servo_pulse == PULSE_MAX)
      else $error("saturated flag with pulse inside range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(servo_pulse) && $stable(los_now)
         && $stable(saturated) && $stable(bad_step))
      else $error("stalled result word changed");

endmodule

bind pro_nav_roll_servo_command_unit pnrs_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .servo_pulse(rsp_ch.servo_pulse),
   .los_now(rsp_ch.los_now),
   .saturated(rsp_ch.saturated),
   .bad_step(rsp_ch.bad_step)
);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
   import pnrs_pkg::*;

   localparam int LATENCY = 2 * CORDIC_STEPS_DEF + 48;

   typedef struct {
      logic [11:0]        servo_pulse;
      logic signed [15:0] los_now;
      logic               saturated;
      logic               bad_step;
   } servo_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   pnrs_req_if req_ch ();
   pnrs_rsp_if rsp_ch ();

   pro_nav_roll_servo_command_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow copy of the guidance registers.
   longint nav_gain_q, roll_gain_q, center_q, ppd_q, gravity_q;

   servo_word_type pending_cmds[$];
   int mismatches = 0;
   int burst_left = 0;
   int stall_period = 1, stall_duty = 1, stall_count = 0, stall_phase = 0;

   always #10 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rel_north = '0;
      req_ch.rel_east = '0;
      req_ch.speed = '0;
      req_ch.prev_los = '0;
      req_ch.roll_now = '0;
      req_ch.step_time = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint table_angle(logic [31:0] a);
      return (longint'(a) + 8192) >>> 14;
   endfunction

   // Vectoring CORDIC: atan2(y, x) with 16 fraction bits.
   function automatic longint vector_angle(longint y, longint x);
      longint unsigned ux, uy;
      longint z, t, dx, dy;
      int s;
      ux = (x < 0) ? -x : x;
      uy = (y < 0) ? -y : y;
      z = 0;
      s = 0;
      if (ux == 0 && uy == 0) return 0;
      while ((ux >> s) >= (64'd1 << 40) || (uy >> s) >= (64'd1 << 40)) s++;
      x = x >>> s;
      y = y >>> s;
      if (x < 0) begin
         if (y >= 0) begin
            t = y; y = -x; x = t;
            z = table_angle(HALF_PI_Q30);
         end else begin
            t = -y; y = x; x = t;
            z = -table_angle(HALF_PI_Q30);
         end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += table_angle(ATAN_Q30[i]);
         end else begin
            x -= dx; y += dy; z -= table_angle(ATAN_Q30[i]);
         end
      end
      return z;
   endfunction

   function automatic servo_word_type predict_servo(longint north, longint east,
                                                    longint speed, longint prev,
                                                    longint roll, longint dt);
      servo_word_type w;
      longint los, rate, num, q, acc, roll_demand, off, pulse;
      longint unsigned mag;
      los = round_half_up(vector_angle(-east, -north), 3);
      if (los > 32767) los = 32767;
      if (los < -32768) los = -32768;
      rate = 0;
      w.bad_step = (dt == 0);
      w.saturated = 1'b0;
      if (dt != 0) begin
         num = (los - prev) * 65536;
         mag = (num < 0) ? -num : num;
         q = longint'((mag + longint'(dt / 2)) / dt);
         rate = (num < 0) ? -q : q;
      end
      acc = nav_gain_q * speed * rate;
      roll_demand = round_half_up(vector_angle(acc, gravity_q << 25) * longint'(R2D_Q16), 25);
      off = roll_gain_q * (roll_demand - roll) * ppd_q;
      pulse = center_q + round_half_up(off, 27);
      if (pulse < 0) begin
         pulse = 0; w.saturated = 1'b1;
      end
      if (pulse > 4095) begin
         pulse = 4095; w.saturated = 1'b1;
      end
      w.servo_pulse = pulse[11:0];
      w.los_now = los[15:0];
      return w;
   endfunction

   task automatic send_word(logic signed [31:0] north, logic signed [31:0] east,
                            logic signed [15:0] speed, logic signed [15:0] prev,
                            logic signed [15:0] roll, logic [15:0] dt);
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_ch.rel_north = north;
      req_ch.rel_east = east;
      req_ch.speed = speed;
      req_ch.prev_los = prev;
      req_ch.roll_now = roll;
      req_ch.step_time = dt;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_cmds.push_back(predict_servo(north, east, speed, prev, roll, dt));
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_ch.valid = 1'b0;
      burst_left = 0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      csr_pwrite = 1'b1;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         REG_NAV_GAIN:         nav_gain_q = value[15:0];
         REG_ROLL_GAIN:        roll_gain_q = value[15:0];
         REG_SERVO_CENTER:     center_q = value[11:0];
         REG_PULSE_PER_DEGREE: ppd_q = value[15:0];
         REG_GRAVITY:          gravity_q = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [15:0] nav, logic [15:0] rg, logic [11:0] center,
                                logic [15:0] ppd, logic [15:0] grav);
      drain_pipeline();
      csr_write(REG_NAV_GAIN, 32'(nav));
      csr_write(REG_ROLL_GAIN, 32'(rg));
      csr_write(REG_SERVO_CENTER, 32'(center));
      csr_write(REG_PULSE_PER_DEGREE, 32'(ppd));
      csr_write(REG_GRAVITY, 32'(grav));
   endtask

   task automatic send_random_word();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         send_word($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                   ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom));
      end else begin
         // Realistic approach geometry: offsets within +/-2^25, a small step and a
         // previous angle anywhere within +/-pi in Q3.13.
         send_word(32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25),
                   32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25),
                   16'($signed($urandom_range(0, 8000)) - 1000),
                   16'($signed($urandom_range(0, 51472)) - 25736),
                   16'($signed($urandom_range(0, 11520)) - 5760),
                   ($urandom_range(0, 30) == 0) ? 16'd0 : 16'($urandom_range(200, 6600)));
      end
   endtask

   task automatic test_extremes();
      send_word(32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
      send_word(-32'sh80000000, -32'sh80000000, -16'sh8000, -16'sh8000, -16'sh8000, 16'h0001);
      send_word(32'sh7fffffff, -32'sh80000000, 16'sh7fff, -16'sh8000, 16'sd0, 16'd1);
      send_word(-32'sh80000000, 32'sh7fffffff, -16'sh8000, 16'sh7fff, 16'sd0, 16'd1);
      // Zero offset gives a zero angle.
      send_word(32'sd0, 32'sd0, 16'sd2560, 16'sd1000, 16'sd0, 16'd1311);
      // Zero step is flagged and the rate is zero.
      send_word(32'sd100000, -32'sd50000, 16'sd2560, 16'sd0, 16'sd640, 16'd0);
      send_word(-32'sd1, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
      send_word(32'sd0, -32'sd1, 16'sd256, 16'sd0, 16'sd0, 16'd1);
      send_word(32'sd1, 32'sd0, 16'sd256, 16'sd0, 16'sd0, 16'd1);
      send_word(32'sd0, 32'sd1, 16'sd256, 16'sd0, 16'sd0, 16'd65535);
      send_word(-32'sd655360, 32'sd0, 16'sd2560, -16'sd100, -16'sd11520, 16'd1311);
      send_word(32'sd655360, 32'sd1, 16'sd2560, 16'sd25000, 16'sd11520, 16'd1311);
   endtask

   task automatic test_settings_extremes();
      load_settings(16'hffff, 16'hffff, 12'hfff, 16'hffff, 16'hffff);
      test_extremes();
      // Zero gravity: nonzero gain sends the roll command to the limit by acceleration sign.
      load_settings(16'd0, 16'd0, 12'd0, 16'd0, 16'd0);
      test_extremes();
      load_settings(16'd8192, 16'd8192, 12'd1500, 16'd15097, 16'd0);
      test_extremes();
   endtask

   task automatic test_random_stream();
      for (int p = 0; p < 6; p++) begin
         if (p == 0) load_settings(NAV_GAIN_RST, ROLL_GAIN_RST, SERVO_CENTER_RST,
                                   PULSE_PER_DEGREE_RST, GRAVITY_RST);
         else load_settings(16'($urandom), 16'($urandom_range(0, 16384)), 12'($urandom),
                            16'($urandom_range(0, 30000)), 16'($urandom_range(1, 65535)));
         for (int n = 0; n < 300; n++) begin
            send_random_word();
            // Let the pipeline run dry once in the middle of one pass.
            if (n == 150 && p == 2) drain_pipeline();
         end
      end
   endtask

   // Receiver stall pattern: a duty cycle that is drawn anew whenever its hold count runs out.
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_count = $urandom_range(100, 600);
         stall_period = $urandom_range(1, 6);
         stall_duty = ($urandom_range(0, 2) == 0) ? stall_period
                      : $urandom_range(1, stall_period);
      end
      stall_count--;
      stall_phase = (stall_phase + 1) % stall_period;
      rsp_ch.ready = (stall_phase < stall_duty);
   end

   always @(posedge clock) begin
      servo_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word: pulse %0d los %0d",
                                           rsp_ch.servo_pulse, rsp_ch.los_now);
         end else begin
            exp_w = pending_cmds.pop_front();
            if (rsp_ch.servo_pulse !== exp_w.servo_pulse || rsp_ch.los_now !== exp_w.los_now
                || rsp_ch.saturated !== exp_w.saturated
                || rsp_ch.bad_step !== exp_w.bad_step) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected pulse %0d los %0d sat %0b bad %0b, got %0d %0d %0b %0b",
                           exp_w.servo_pulse, exp_w.los_now, exp_w.saturated, exp_w.bad_step,
                           rsp_ch.servo_pulse, rsp_ch.los_now, rsp_ch.saturated,
                           rsp_ch.bad_step);
            end
         end
      end
   end

   initial begin
      nav_gain_q = NAV_GAIN_RST;
      roll_gain_q = ROLL_GAIN_RST;
      center_q = SERVO_CENTER_RST;
      ppd_q = PULSE_PER_DEGREE_RST;
      gravity_q = GRAVITY_RST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_settings_extremes();
      test_random_stream();
      drain_pipeline();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
